[hdl/obmm_pkg.sv]
package obmm_pkg;

   localparam int DIV_BITS = 96;
   localparam int DIV_CW = 7;

   localparam logic [63:0] CAP_Q30 = 64'h0000_0000_4000_0000;
   localparam logic [63:0] CAP_S47 = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] CAP_U48 = 64'h0000_FFFF_FFFF_FFFF;
   localparam logic [63:0] CAP_S63 = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam logic REQ_TRADE = 1'b0;
   localparam logic REQ_LEVEL = 1'b1;

   localparam int FLAG_VOL = 0;
   localparam int FLAG_TOX = 1;
   localparam int FLAG_SPR = 2;
   localparam int FLAG_DEP = 3;
   localparam int FLAG_RES = 4;

   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [63:0] den;
      logic [5:0]  shift;
      logic [63:0] cap;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quo;
   } div_rsp_type;

   typedef struct packed {
      logic [23:0] price;
      logic [23:0] vol;
      logic        buy;
      logic [47:0] tstamp;
   } trade_entry_type;

   typedef enum logic [14:0] {
      ST_IDLE     = 15'b000000000000001,
      ST_LV_BID   = 15'b000000000000010,
      ST_LV_ASK   = 15'b000000000000100,
      ST_LV_PAIR  = 15'b000000000001000,
      ST_VOL      = 15'b000000000010000,
      ST_WALK_RD  = 15'b000000000100000,
      ST_WALK_ACC = 15'b000000001000000,
      ST_WALK_DIV = 15'b000000010000000,
      ST_TOX      = 15'b000000100000000,
      ST_SPR      = 15'b000001000000000,
      ST_DEP      = 15'b000010000000000,
      ST_MEAN     = 15'b000100000000000,
      ST_REC      = 15'b001000000000000,
      ST_RES      = 15'b010000000000000,
      ST_OUT      = 15'b100000000000000
   } state_type;

endpackage

[hdl/obmm_div.sv]
module obmm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  obmm_pkg::div_req_type div_req,
   output obmm_pkg::div_rsp_type div_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [obmm_pkg::DIV_CW-1:0]   cnt_ff, cnt_in;
   logic [obmm_pkg::DIV_BITS-1:0] dvd_ff, dvd_in;
   logic [obmm_pkg::DIV_BITS-1:0] quo_ff, quo_in;
   logic [63:0]                   rem_ff, rem_in;
   logic [63:0]                   den_ff, den_in;
   logic [63:0]                   cap_ff, cap_in;
   logic [64:0]                   rem_sh;
   logic                          ge;

   // restoring division, one quotient bit a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cap_in  = cap_ff;
      rem_sh  = {rem_ff, dvd_ff[obmm_pkg::DIV_BITS-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = obmm_pkg::DIV_CW'(obmm_pkg::DIV_BITS - 1);
         dvd_in  = {32'b0, div_req.num} << div_req.shift;
         quo_in  = '0;
         rem_in  = '0;
         den_in  = div_req.den;
         cap_in  = div_req.cap;
      end else if (busy_ff) begin
         rem_in = ge ? 64'(rem_sh - {1'b0, den_ff}) : rem_sh[63:0];
         quo_in = {quo_ff[obmm_pkg::DIV_BITS-2:0], ge};
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cap_ff <= cap_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = (quo_ff > {32'b0, cap_ff}) ? cap_ff : quo_ff[63:0];

endmodule

[hdl/obmm_ring.sv]
module obmm_ring #(
   parameter int DEPTH = 64,
   parameter int IW = 6
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IW-1:0]            wr_idx,
   input  obmm_pkg::trade_entry_type wr_data,
   input  logic [IW-1:0]            rd_idx,
   output obmm_pkg::trade_entry_type rd_data
);

   obmm_pkg::trade_entry_type mem [DEPTH];
   obmm_pkg::trade_entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_ff <= mem[rd_idx];
   end

   assign rd_data = rd_ff;

endmodule

[hdl/order_book_microstructure_metrics.sv]
// Order book metrics. A trade item (tuser 0) goes into a ring of the last
// TRADE_WINDOW nonzero-volume trades. A book level item (tuser 1) is worked through
// the states LV_BID, LV_ASK and LV_PAIR: one shared 26x26 multiplier adds bid
// notional, ask notional and the weighted spread in turn. The level marked tlast
// starts the snapshot, which runs every quotient through one bit-serial divider of
// 96 steps; a step whose divisor is zero skips the divider. req_tready is low while
// a level or a snapshot is in work; one finished result waits in the output
// register while the next items are taken.
module order_book_microstructure_metrics #(
   parameter int MAX_LEVELS = 16,
   parameter int TRADE_WINDOW = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // bid_price, bid_volume, bid_present, ask_price, ask_volume, ask_present,
   // trade_price, trade_volume, trade_buy, trade_time_ms
   input  logic [199:0] req_tdata,
   input  logic         req_tuser,  // req_type
   input  logic         req_tlast,  // last_level
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // volume_imbalance, flow_toxicity, effective_spread, depth_imbalance,
   // resiliency, undefined_flags
   output logic [199:0] rsp_tdata
);

   localparam int LW   = $clog2(MAX_LEVELS + 1);
   localparam int IW   = (TRADE_WINDOW > 2) ? $clog2(TRADE_WINDOW) : 1;
   localparam int HW   = $clog2(TRADE_WINDOW + 1);
   localparam int VOLW = 24 + LW;
   localparam int NOTW = 48 + LW;
   localparam int SPRW = 51 + LW;
   localparam int PRW  = 25 + LW;
   localparam int BSW  = 24 + HW;
   localparam int DSW  = 24 + HW;
   localparam int TSW  = 48 + HW;
   localparam int ISW  = 42 + HW;

   obmm_pkg::state_type state_ff, state_in;

   // book accumulators
   logic [VOLW-1:0]        bvol_ff, bvol_in, avol_ff, avol_in;
   logic [NOTW-1:0]        bnot_ff, bnot_in, anot_ff, anot_in;
   logic signed [SPRW-1:0] spr_ff, spr_in;
   logic [PRW-1:0]         pair_ff, pair_in;
   logic [23:0]            bbid_ff, bbid_in, bask_ff, bask_in;
   logic [LW-1:0]          lvls_ff, lvls_in;

   // latched level item
   logic [23:0] lbp_ff, lbp_in, lbv_ff, lbv_in, lap_ff, lap_in, lav_ff, lav_in;
   logic        lbh_ff, lbh_in, lah_ff, lah_in, llast_ff, llast_in;

   // trade ring control
   logic [IW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [HW-1:0] held_ff, held_in, k_ff, k_in;

   // walk accumulators
   logic [BSW-1:0] buy_ff, buy_in, sell_ff, sell_in;
   logic [DSW-1:0] dsum_ff, dsum_in;
   logic [TSW-1:0] tsum_ff, tsum_in;
   logic [ISW-1:0] isum_ff, isum_in;
   logic [23:0]    pp_ff, pp_in, wv_ff, wv_in;
   logic [47:0]    pt_ff, pt_in;
   logic [24:0]    dev_ff, dev_in;
   logic [63:0]    mean_ff, mean_in, rec_ff, rec_in;

   // results
   logic [31:0] vi_ff, vi_in, di_ff, di_in;
   logic [30:0] tox_ff, tox_in;
   logic [47:0] es_ff, es_in, res_ff, res_in;
   logic [4:0]  flg_ff, flg_in;
   logic        wait_ff, wait_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [199:0] rsp_data_ff, rsp_data_in;

   obmm_pkg::div_req_type     div_req;
   obmm_pkg::div_rsp_type     div_rsp;
   obmm_pkg::trade_entry_type wr_entry, rd_entry;
   logic                      wr_en;

   logic signed [25:0] mul_a, mul_b;
   logic signed [51:0] prod;

   logic                   req_fire;
   logic [HW:0]            oldest;
   logic [24:0]            mid2, p2;
   logic [23:0]            pdiff;
   logic [VOLW:0]          vsum;
   logic [NOTW:0]          nsum;
   logic [BSW:0]           tsumbs;
   logic [63:0]            smag;
   logic                   zero_den;

   assign req_tready = state_ff == obmm_pkg::ST_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign wr_en    = req_fire && req_tuser == obmm_pkg::REQ_TRADE && req_tdata[145:122] != '0;
   assign wr_entry = '{price: req_tdata[121:98], vol: req_tdata[145:122],
                       buy: req_tdata[146], tstamp: req_tdata[194:147]};

   obmm_ring #(.DEPTH(TRADE_WINDOW), .IW(IW)) u_ring (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_idx (wr_ff),
      .wr_data(wr_entry),
      .rd_idx (rd_ff),
      .rd_data(rd_entry)
   );

   obmm_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   // shared level multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         obmm_pkg::ST_LV_BID: begin
            mul_a = {2'b0, lbp_ff};
            mul_b = {2'b0, lbv_ff};
         end
         obmm_pkg::ST_LV_ASK: begin
            mul_a = {2'b0, lap_ff};
            mul_b = {2'b0, lav_ff};
         end
         default: begin
            mul_a = 26'({1'b0, lap_ff}) - 26'({1'b0, lbp_ff});
            mul_b = 26'({1'b0, lbv_ff}) + 26'({1'b0, lav_ff});
         end
      endcase
      prod = mul_a * mul_b;
   end

   assign oldest = ({1'b0, HW'(wr_ff)} >= {1'b0, held_ff})
                   ? ({1'b0, HW'(wr_ff)} - {1'b0, held_ff})
                   : ({1'b0, HW'(wr_ff)} + (HW+1)'(TRADE_WINDOW) - {1'b0, held_ff});
   assign mid2   = {1'b0, bbid_ff} + {1'b0, bask_ff};
   assign p2     = {rd_entry.price, 1'b0};
   assign pdiff  = (rd_entry.price >= pp_ff) ? rd_entry.price - pp_ff : pp_ff - rd_entry.price;
   assign vsum   = {1'b0, bvol_ff} + {1'b0, avol_ff};
   assign nsum   = {1'b0, bnot_ff} + {1'b0, anot_ff};
   assign tsumbs = {1'b0, buy_ff} + {1'b0, sell_ff};
   assign smag   = spr_ff[SPRW-1] ? 64'(-spr_ff) : 64'(spr_ff);

   // divider operands by snapshot step
   always_comb begin
      div_req       = '0;
      div_req.shift = 6'd30;
      div_req.cap   = obmm_pkg::CAP_Q30;
      unique case (state_ff)
         obmm_pkg::ST_VOL: begin
            div_req.start = 1'b1;
            div_req.num = (bvol_ff >= avol_ff) ? 64'(bvol_ff - avol_ff) : 64'(avol_ff - bvol_ff);
            div_req.den = 64'(vsum);
         end
         obmm_pkg::ST_WALK_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = 64'(dev_ff);
            div_req.den   = 64'({wv_ff, 1'b0});
            div_req.shift = 6'd16;
            div_req.cap   = obmm_pkg::CAP_S63;
         end
         obmm_pkg::ST_TOX: begin
            div_req.start = 1'b1;
            div_req.num = (buy_ff >= sell_ff) ? 64'(buy_ff - sell_ff) : 64'(sell_ff - buy_ff);
            div_req.den = 64'(tsumbs);
         end
         obmm_pkg::ST_SPR: begin
            div_req.start = 1'b1;
            div_req.num   = smag;
            div_req.den   = 64'(pair_ff);
            div_req.shift = 6'd16;
            div_req.cap   = obmm_pkg::CAP_S47;
         end
         obmm_pkg::ST_DEP: begin
            div_req.start = 1'b1;
            div_req.num = (bnot_ff >= anot_ff) ? 64'(bnot_ff - anot_ff) : 64'(anot_ff - bnot_ff);
            div_req.den = 64'(nsum);
         end
         obmm_pkg::ST_MEAN: begin
            div_req.start = 1'b1;
            div_req.num   = 64'(isum_ff);
            div_req.den   = 64'(held_ff);
            div_req.shift = 6'd0;
            div_req.cap   = obmm_pkg::CAP_S63;
         end
         obmm_pkg::ST_REC: begin
            // no recovery rate when the impact term is undefined
            div_req.start = 1'b1;
            div_req.num   = 64'(dsum_ff);
            div_req.den   = (held_ff < HW'(2) || mean_ff == '0) ? '0 : 64'(tsum_ff);
            div_req.shift = 6'd32;
            div_req.cap   = obmm_pkg::CAP_S63;
         end
         obmm_pkg::ST_RES: begin
            div_req.start = 1'b1;
            div_req.num   = rec_ff;
            div_req.den   = mean_ff;
            div_req.shift = 6'd0;
            div_req.cap   = obmm_pkg::CAP_U48;
         end
         default: begin
            div_req.num = '0;
            div_req.den = '0;
         end
      endcase
      zero_den      = div_req.den == '0;
      div_req.start = div_req.start && !wait_ff && !zero_den;
   end

   always_comb begin
      state_in = state_ff;
      bvol_in = bvol_ff;  avol_in = avol_ff;  bnot_in = bnot_ff;  anot_in = anot_ff;
      spr_in = spr_ff;    pair_in = pair_ff;  bbid_in = bbid_ff;  bask_in = bask_ff;
      lvls_in = lvls_ff;
      lbp_in = lbp_ff;  lbv_in = lbv_ff;  lap_in = lap_ff;  lav_in = lav_ff;
      lbh_in = lbh_ff;  lah_in = lah_ff;  llast_in = llast_ff;
      wr_in = wr_ff;  rd_in = rd_ff;  held_in = held_ff;  k_in = k_ff;
      buy_in = buy_ff;  sell_in = sell_ff;  dsum_in = dsum_ff;  tsum_in = tsum_ff;
      isum_in = isum_ff;  pp_in = pp_ff;  pt_in = pt_ff;  wv_in = wv_ff;  dev_in = dev_ff;
      mean_in = mean_ff;  rec_in = rec_ff;
      vi_in = vi_ff;  di_in = di_ff;  tox_in = tox_ff;  es_in = es_ff;  res_in = res_ff;
      flg_in = flg_ff;
      wait_in = wait_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (div_req.start) begin
         wait_in = 1'b1;
      end
      if (div_rsp.done) begin
         wait_in = 1'b0;
      end

      unique case (state_ff)
         obmm_pkg::ST_IDLE: begin
            if (wr_en) begin
               wr_in = (wr_ff == IW'(TRADE_WINDOW - 1)) ? '0 : wr_ff + 1'b1;
               if (held_ff != HW'(TRADE_WINDOW)) begin
                  held_in = held_ff + 1'b1;
               end
            end
            if (req_fire && req_tuser == obmm_pkg::REQ_LEVEL) begin
               lbp_in = req_tdata[23:0];   lbv_in = req_tdata[47:24];
               lbh_in = req_tdata[48];     lap_in = req_tdata[72:49];
               lav_in = req_tdata[96:73];  lah_in = req_tdata[97];
               llast_in = req_tlast;
               if (lvls_ff != LW'(MAX_LEVELS)) begin
                  state_in = obmm_pkg::ST_LV_BID;
               end else if (req_tlast) begin
                  state_in = obmm_pkg::ST_VOL;
               end
            end
         end
         obmm_pkg::ST_LV_BID: begin
            if (lvls_ff == '0) begin
               bbid_in = lbh_ff ? lbp_ff : '0;
               bask_in = lah_ff ? lap_ff : '0;
            end
            if (lbh_ff) begin
               bvol_in = bvol_ff + VOLW'(lbv_ff);
               bnot_in = bnot_ff + NOTW'(prod[47:0]);
            end
            state_in = obmm_pkg::ST_LV_ASK;
         end
         obmm_pkg::ST_LV_ASK: begin
            if (lah_ff) begin
               avol_in = avol_ff + VOLW'(lav_ff);
               anot_in = anot_ff + NOTW'(prod[47:0]);
            end
            state_in = obmm_pkg::ST_LV_PAIR;
         end
         obmm_pkg::ST_LV_PAIR: begin
            if (lbh_ff && lah_ff) begin
               spr_in  = spr_ff + SPRW'(prod);
               pair_in = pair_ff + PRW'({1'b0, lbv_ff} + {1'b0, lav_ff});
            end
            lvls_in  = lvls_ff + 1'b1;
            state_in = llast_ff ? obmm_pkg::ST_VOL : obmm_pkg::ST_IDLE;
         end
         obmm_pkg::ST_VOL: begin
            buy_in = '0;  sell_in = '0;  dsum_in = '0;  tsum_in = '0;  isum_in = '0;
            k_in = '0;  rd_in = IW'(oldest);
            if (zero_den) begin
               vi_in = '0;
               flg_in = 5'b0;
               flg_in[obmm_pkg::FLAG_VOL] = 1'b1;
               state_in = (held_ff == '0) ? obmm_pkg::ST_TOX : obmm_pkg::ST_WALK_RD;
            end else if (div_rsp.done) begin
               vi_in = (bvol_ff < avol_ff) ? -div_rsp.quo[31:0] : div_rsp.quo[31:0];
               flg_in = 5'b0;
               state_in = (held_ff == '0) ? obmm_pkg::ST_TOX : obmm_pkg::ST_WALK_RD;
            end
         end
         obmm_pkg::ST_WALK_RD: begin
            state_in = obmm_pkg::ST_WALK_ACC;
         end
         obmm_pkg::ST_WALK_ACC: begin
            if (rd_entry.buy) begin
               buy_in = buy_ff + BSW'(rd_entry.vol);
            end else begin
               sell_in = sell_ff + BSW'(rd_entry.vol);
            end
            if (k_ff != '0) begin
               dsum_in = dsum_ff + DSW'(pdiff);
               tsum_in = tsum_ff + TSW'(48'(rd_entry.tstamp - pt_ff));
            end
            pp_in  = rd_entry.price;
            pt_in  = rd_entry.tstamp;
            wv_in  = rd_entry.vol;
            dev_in = (p2 >= mid2) ? p2 - mid2 : mid2 - p2;
            state_in = obmm_pkg::ST_WALK_DIV;
         end
         obmm_pkg::ST_WALK_DIV: begin
            if (div_rsp.done) begin
               isum_in = isum_ff + ISW'(div_rsp.quo);
               k_in    = k_ff + 1'b1;
               rd_in   = (rd_ff == IW'(TRADE_WINDOW - 1)) ? '0 : rd_ff + 1'b1;
               state_in = (k_ff + 1'b1 == held_ff) ? obmm_pkg::ST_TOX : obmm_pkg::ST_WALK_RD;
            end
         end
         obmm_pkg::ST_TOX: begin
            if (zero_den) begin
               tox_in = '0;
               flg_in[obmm_pkg::FLAG_TOX] = 1'b1;
               state_in = obmm_pkg::ST_SPR;
            end else if (div_rsp.done) begin
               tox_in = div_rsp.quo[30:0];
               state_in = obmm_pkg::ST_SPR;
            end
         end
         obmm_pkg::ST_SPR: begin
            if (zero_den) begin
               es_in = '0;
               flg_in[obmm_pkg::FLAG_SPR] = 1'b1;
               state_in = obmm_pkg::ST_DEP;
            end else if (div_rsp.done) begin
               es_in = spr_ff[SPRW-1] ? -div_rsp.quo[47:0] : div_rsp.quo[47:0];
               state_in = obmm_pkg::ST_DEP;
            end
         end
         obmm_pkg::ST_DEP: begin
            if (zero_den) begin
               di_in = '0;
               flg_in[obmm_pkg::FLAG_DEP] = 1'b1;
               state_in = obmm_pkg::ST_MEAN;
            end else if (div_rsp.done) begin
               di_in = (bnot_ff < anot_ff) ? -div_rsp.quo[31:0] : div_rsp.quo[31:0];
               state_in = obmm_pkg::ST_MEAN;
            end
         end
         obmm_pkg::ST_MEAN: begin
            if (zero_den) begin
               mean_in  = '0;
               state_in = obmm_pkg::ST_REC;
            end else if (div_rsp.done) begin
               mean_in  = div_rsp.quo;
               state_in = obmm_pkg::ST_REC;
            end
         end
         obmm_pkg::ST_REC: begin
            if (held_ff < HW'(2) || zero_den || mean_ff == '0) begin
               res_in = '0;
               flg_in[obmm_pkg::FLAG_RES] = 1'b1;
               wait_in = 1'b0;
               state_in = obmm_pkg::ST_OUT;
            end else if (div_rsp.done) begin
               rec_in   = div_rsp.quo;
               state_in = obmm_pkg::ST_RES;
            end
         end
         obmm_pkg::ST_RES: begin
            if (div_rsp.done) begin
               res_in   = div_rsp.quo[47:0];
               state_in = obmm_pkg::ST_OUT;
            end
         end
         obmm_pkg::ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, flg_ff, res_ff, di_ff, es_ff, tox_ff, vi_ff};
               bvol_in = '0;  avol_in = '0;  bnot_in = '0;  anot_in = '0;
               spr_in = '0;   pair_in = '0;  bbid_in = '0;  bask_in = '0;
               lvls_in = '0;
               state_in = obmm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = obmm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= obmm_pkg::ST_IDLE;
         bvol_ff <= '0;  avol_ff <= '0;  bnot_ff <= '0;  anot_ff <= '0;
         spr_ff <= '0;   pair_ff <= '0;  bbid_ff <= '0;  bask_ff <= '0;
         lvls_ff <= '0;
         wr_ff <= '0;    held_ff <= '0;
         wait_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bvol_ff <= bvol_in;  avol_ff <= avol_in;  bnot_ff <= bnot_in;  anot_ff <= anot_in;
         spr_ff <= spr_in;    pair_ff <= pair_in;  bbid_ff <= bbid_in;  bask_ff <= bask_in;
         lvls_ff <= lvls_in;
         wr_ff <= wr_in;      held_ff <= held_in;
         wait_ff <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lbp_ff <= lbp_in;  lbv_ff <= lbv_in;  lap_ff <= lap_in;  lav_ff <= lav_in;
      lbh_ff <= lbh_in;  lah_ff <= lah_in;  llast_ff <= llast_in;
      rd_ff <= rd_in;    k_ff <= k_in;
      buy_ff <= buy_in;  sell_ff <= sell_in;  dsum_ff <= dsum_in;  tsum_ff <= tsum_in;
      isum_ff <= isum_in;  pp_ff <= pp_in;  pt_ff <= pt_in;  wv_ff <= wv_in;
      dev_ff <= dev_in;  mean_ff <= mean_in;  rec_ff <= rec_in;
      vi_ff <= vi_in;  di_ff <= di_in;  tox_ff <= tox_in;  es_ff <= es_in;  res_ff <= res_in;
      flg_ff <= flg_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy && !wait_ff)
      else $error("divider started while busy");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> wait_ff)
      else $error("divider result without a pending request");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HW'(TRADE_WINDOW) && lvls_ff <= LW'(MAX_LEVELS))
      else $error("trade or level count out of range");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == obmm_pkg::REQ_LEVEL && req_tlast |=> !req_tready)
      else $error("last level did not start a snapshot");

endmodule
